[rtl/mwdds_pkg.sv]
// ----------------------------------------------------------------------------
// mwdds_pkg
// Shared codes, widths and the quarter-wave sine table generator for the
// multi-waveform DDS tone generator.
// ----------------------------------------------------------------------------
package mwdds_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WAVE_SELECT     = 2'd0;
	localparam logic [1:0] CFG_PHASE_INCREMENT = 2'd1;
	localparam logic [1:0] CFG_AMPLITUDE       = 2'd2;

	// Waveform codes.
	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAWTOOTH = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	localparam int CFG_DATA_BITS  = 32;
	localparam int INCR_BITS      = 32;
	localparam int AMP_BITS       = 15;
	localparam int SAMPLE_BITS    = 16;
	localparam int WAVE_BITS      = 18;   // signed Q3.15 value, -1.0 .. +1.0
	localparam int ENTRY_BITS     = 16;   // table entry 0 .. 32768

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// Divide a Taylor term by (2n)(2n+1) for series step n.
	function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
		case (n)
			1: return t / 64'd6;
			2: return t / 64'd20;
			3: return t / 64'd42;
			4: return t / 64'd72;
			5: return t / 64'd110;
			6: return t / 64'd156;
			7: return t / 64'd210;
			default: return t / 64'd272;   // last series step
		endcase
	endfunction

	// Quarter-wave sine entry k of a table with 2^tbits steps, Q30 Taylor series,
	// scaled to 32768 and rounded half up. Evaluated at elaboration only.
	function automatic logic [ENTRY_BITS-1:0] sine_entry(input int k, input int tbits);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		logic [63:0] v;
		x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = taylor_div(term, n);
			if ((n % 2) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = ((64'(sum) * 64'd32768) + (ONE_Q30 >> 1)) >> 30;
		if (v > 64'd32768)
			v = 64'd32768;
		return v[ENTRY_BITS-1:0];
	endfunction

endpackage

[rtl/multi_waveform_dds.sv]
// ----------------------------------------------------------------------------
// multi_waveform_dds
// Phase-accumulator tone generator: one signed sample per sample tick, as
// amplitude times a sine, sawtooth, square or triangle at the current phase, or zero for a zero increment.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                        | Content
//  ---------+-----------+--------------------------------+---------------------------
//  s_*      | in        | s_tvalid, s_tready, s_tdata    | sample tick, bit 0 restart
//  m_*      | out       | m_tvalid, m_tready, m_tdata    | signed 16-bit sample
//  cfg_*    | in        | cfg_we, cfg_index, cfg_data    | register writes, no wait
//
// One transfer is accepted per clock cycle when the output side keeps up.
// Each sample passes these stages after its tick: one stage forms the table
// address and the non-sine values, one stage is the registered read of the
// sine table, one stage holds the amplitude multiply. Every stage holds its
// own valid bit, so bubbles are squeezed out and a waiting result never
// blocks the stages behind it until the pipe is full. Reset clears the phase,
// the configuration registers and all valid bits; the constant table needs no fill.
//
module multi_waveform_dds
	import mwdds_pkg::*;
#(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,    // [0] restart, [7:1] zero
	// Output stream.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [SAMPLE_BITS-1:0]   m_tdata,    // [15:0] sample (signed)
	// Configuration write port.
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int QSIZE    = 1 << SINE_TABLE_BITS;
	localparam int SUM_BITS = (PHASE_BITS > 32) ? PHASE_BITS : 32;
	localparam logic [SINE_TABLE_BITS:0] QSIZE_IDX = {1'b1, {SINE_TABLE_BITS{1'b0}}};

	// Configuration registers.
	wave_t                wave_select_q;
	logic [INCR_BITS-1:0] phase_increment_q;
	logic [AMP_BITS-1:0]  amplitude_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q     <= WAVE_SINE;
			phase_increment_q <= '0;
			amplitude_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAVE_SELECT:     wave_select_q     <= wave_t'(cfg_data[1:0]);
				CFG_PHASE_INCREMENT: phase_increment_q <= cfg_data[INCR_BITS-1:0];
				CFG_AMPLITUDE:       amplitude_q       <= cfg_data[AMP_BITS-1:0];
				default: ;   // writes to unused indexes are dropped
			endcase
		end
	end

	// Stage handshake: a stage may load when it is empty or its content moves on.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	logic accept;
	assign accept = s_tvalid && s_tready;

	// Phase accumulator. The sample uses the phase held before the advance,
	// after an optional restart.
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_base;
	logic [SUM_BITS-1:0]   phase_sum;
	logic [31:0]           phase_top;

	assign phase_base = s_tdata[0] ? '0 : phase_q;
	assign phase_sum  = SUM_BITS'(phase_base) + SUM_BITS'(phase_increment_q);

	// The waveform always looks at the top 32 bits of the phase fraction.
	generate
		if (PHASE_BITS >= 32) begin : g_phase_wide
			assign phase_top = phase_base[PHASE_BITS-1 -: 32];
		end else begin : g_phase_narrow
			assign phase_top = {phase_base, {(32-PHASE_BITS){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= '0;
		else if (accept)
			phase_q <= phase_sum[PHASE_BITS-1:0];
	end

	// Stage 1: phase of the item.
	logic [31:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept)
			p_s1 <= phase_top;
	end

	// Table address: quadrant from the top two bits, mirrored in odd quadrants.
	logic [SINE_TABLE_BITS-1:0] r_s1;
	logic [SINE_TABLE_BITS:0]   rom_idx;
	logic [31:0]                tri_dist;
	logic signed [WAVE_BITS-1:0] alt_w;

	assign r_s1    = p_s1[29 -: SINE_TABLE_BITS];
	assign rom_idx = p_s1[30] ? (QSIZE_IDX - {1'b0, r_s1}) : {1'b0, r_s1};

	// Triangle: distance from phase zero, folded at one half.
	assign tri_dist = p_s1[31] ? (~p_s1 + 32'd1) : p_s1;

	always_comb begin
		case (wave_select_q)
			WAVE_SAWTOOTH: alt_w = $signed({3'b000, p_s1[31:17]});
			default:       alt_w = $signed({1'b0, tri_dist[31:15]}) - WAVE_BITS'(32768);
		endcase
	end

	// Quarter-wave sine table, constant at elaboration.
	logic [ENTRY_BITS-1:0] rom [QSIZE+1];

	generate
		for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
			assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
		end
	endgenerate

	// Stage 2: registered table read plus the non-sine value. Only the sign
	// of the quadrant travels on, since the mirroring is already done.
	logic [ENTRY_BITS-1:0]       mag_s2;
	logic                        neg_s2;
	logic signed [WAVE_BITS-1:0] alt_w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			mag_s2   <= rom[rom_idx];
			neg_s2   <= p_s1[31];
			alt_w_s2 <= alt_w;
		end
	end

	// Waveform value and product, truncated toward zero.
	logic signed [WAVE_BITS-1:0]    sine_w;
	logic signed [WAVE_BITS-1:0]    wave_w;
	logic signed [AMP_BITS+WAVE_BITS:0] prod;
	logic signed [AMP_BITS+WAVE_BITS:0] prod_adj;
	logic signed [AMP_BITS+WAVE_BITS:0] prod_shr;
	logic [SAMPLE_BITS-1:0]         sample;

	assign sine_w = neg_s2 ? -$signed({2'b00, mag_s2}) : $signed({2'b00, mag_s2});

	always_comb begin
		case (wave_select_q)
			WAVE_SINE:   wave_w = sine_w;
			// Square follows the sign of the table sine; a zero sine counts as positive.
			WAVE_SQUARE: wave_w = (neg_s2 && (mag_s2 != '0)) ? -WAVE_BITS'(32768)
			                                                  : WAVE_BITS'(32768);
			default:     wave_w = alt_w_s2;
		endcase
	end

	assign prod     = $signed({1'b0, amplitude_q}) * wave_w;
	assign prod_adj = prod + ((prod < 0) ? (AMP_BITS+WAVE_BITS+1)'(32767) : '0);
	assign prod_shr = prod_adj >>> 15;
	assign sample   = (phase_increment_q == '0) ? '0 : prod_shr[SAMPLE_BITS-1:0];

	// Stage 3: output register.
	logic [SAMPLE_BITS-1:0] sample_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2)
			sample_s3 <= sample;
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = sample_s3;

endmodule

[rtl/mwdds_checker.sv]
// ----------------------------------------------------------------------------
// mwdds_checker
// Port-level checks of the multi-waveform DDS tone generator, bound to it.
// ----------------------------------------------------------------------------
module mwdds_checker
	import mwdds_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [SAMPLE_BITS-1:0]   m_tdata
);

	// A clock edge seen in reset leaves no sample offered at the next edge.
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid after reset");

	// A held sample keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output sample changed while stalled");

	// With nothing waiting at the output, the pipe has room for a tick.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// The product is truncated toward zero, so full negative scale never occurs.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("sample outside the symmetric range");

endmodule

bind multi_waveform_dds mwdds_checker u_mwdds_checker (.*);

[tb/tb_multi_waveform_dds.sv]
// ----------------------------------------------------------------------------
// tb_multi_waveform_dds
// Self-checking bench for the multi-waveform DDS tone generator. A scoreboard
// keeps its own phase accumulator, sine table and register copies, predicts
// the sample for every accepted tick and compares it with the sample stream.
// A short directed part hits the quadrant points of sine, square and
// triangle, the extremes of gain and tuning word and the zero-increment
// case. Many random tone settings follow under changing handshake pressure.
// ----------------------------------------------------------------------------
module tb_multi_waveform_dds
	import mwdds_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_BITS  = 10;
	localparam int TABLE_STEPS = 1 << TABLE_BITS;
	// Cycles without any transfer before the run is declared hung.
	localparam int HANG_LIMIT  = 2000;
	// Pipeline depth is three stages; leave a margin before touching registers.
	localparam int SETTLE_CYCLES = 8;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts one sample per accepted tick and checks the output
	// stream in order.
	// ------------------------------------------------------------------------
	class tone_scoreboard;
		logic [15:0]        quarter_sine [0:TABLE_STEPS];
		wave_t              wave;
		logic [31:0]        tuning;
		logic [14:0]        gain;
		logic [31:0]        phase;
		logic signed [15:0] pending_samples [$];
		int                 mismatches;
		int                 checked;
		int                 restarts;
		int                 per_wave [4];

		function new();
			longint unsigned x;
			longint unsigned term;
			longint          acc;
			longint          v;
			for (int k = 0; k <= TABLE_STEPS; k++) begin
				// Angle k/TABLE_STEPS of a quarter turn in Q30, then a Taylor series.
				x    = (64'd1686629713 * 64'(k)) >> TABLE_BITS;
				term = x;
				acc  = longint'(x);
				for (int n = 1; n <= 8; n++) begin
					term = (term * x) >> 30;
					term = (term * x) >> 30;
					term = term / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1)
						acc = acc - longint'(term);
					else
						acc = acc + longint'(term);
				end
				if (acc < 0)
					acc = 0;
				v = (acc * 32768 + (longint'(1) << 29)) >>> 30;
				if (v > 32768)
					v = 32768;
				quarter_sine[k] = v[15:0];
			end
			wave       = WAVE_SINE;
			tuning     = '0;
			gain       = '0;
			phase      = '0;
			mismatches = 0;
			checked    = 0;
			restarts   = 0;
			per_wave   = '{default: 0};
		endfunction

		// Register bits above each register's width are dropped.
		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_WAVE_SELECT:     wave   = wave_t'(data[1:0]);
				CFG_PHASE_INCREMENT: tuning = data;
				CFG_AMPLITUDE:       gain   = data[14:0];
				default: ;
			endcase
		endfunction

		function int sine_at(logic [31:0] p);
			int r;
			int mag;
			r = int'(p[29:20]);
			// Odd quadrants read the table backwards, the lower half is negated.
			mag = p[30] ? int'(quarter_sine[TABLE_STEPS - r]) : int'(quarter_sine[r]);
			return p[31] ? -mag : mag;
		endfunction

		// Waveform value in Q1.15, where 32768 stands for 1.0.
		function int shape_at(logic [31:0] p);
			longint d;
			case (wave)
				WAVE_SINE:     return sine_at(p);
				WAVE_SAWTOOTH: return int'(p[31:17]);
				WAVE_SQUARE:   return (sine_at(p) >= 0) ? 32768 : -32768;
				default: begin
					// Triangle: distance from phase zero, folded at one half.
					d = p[31] ? (longint'(1) << 32) - longint'(p) : longint'(p);
					return int'(d >>> 15) - 32768;
				end
			endcase
		endfunction

		function void note_tick(logic restart);
			int prod;
			if (restart) begin
				phase = '0;
				restarts++;
			end
			if (tuning == '0)
				prod = 0;
			else
				prod = (int'({17'b0, gain}) * shape_at(phase)) / 32768;
			pending_samples.push_back(prod[15:0]);
			per_wave[int'(wave)]++;
			phase = phase + tuning;
		endfunction

		function void check_sample(logic [15:0] got);
			logic signed [15:0] want;
			if (pending_samples.size() == 0) begin
				$error("sample: unexpected transfer, value %0d", $signed(got));
				mismatches++;
				return;
			end
			want = pending_samples.pop_front();
			checked++;
			if (got !== want) begin
				$error("sample mismatch: expected %0d, actual %0d", want, $signed(got));
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block under test. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;    // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;           // [15:0] sample (signed)
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	always #10 clk = ~clk;

	multi_waveform_dds i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tone_scoreboard tone_sb = new();

	// Percentages of cycles in which the tick source holds back and in which
	// the sample sink refuses a transfer. The main sequence changes them.
	int send_idle_pct  = 8;
	int recv_stall_pct = 54;
	int tone_settings  = 0;
	int idle_cycles    = 0;

	wire tick_xfer   = s_tvalid && s_tready;
	wire sample_xfer = m_tvalid && m_tready;

	// ------------------------------------------------------------------------
	// Monitors. Everything is sampled at the rising edge, so register writes,
	// tick transfers and sample transfers reach the scoreboard in the order
	// in which the block sees them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tone_sb.write_reg(cfg_index, cfg_data);
			if (tick_xfer)
				tone_sb.note_tick(s_tdata[0]);
			if (sample_xfer)
				tone_sb.check_sample(m_tdata);
		end
	end

	// Watchdog: only cycles with no transfer at all count toward the limit.
	always @(posedge clk) begin
		if (!arst_n || tick_xfer || sample_xfer)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The sink stalls at random; with a zero percentage it is always ready.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Driver tasks. All of them start and end at a falling edge.
	// ------------------------------------------------------------------------

	// One register write per call; the enable drops on the following cycle so
	// that no edge sees two assignments to it.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offers one tick, possibly after some idle cycles, and holds it until the
	// block takes the transfer. tvalid stays high into the next call.
	task automatic send_tick(input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, restart};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Waits until every predicted sample has come out, then lets the pipeline
	// settle so that registers can be rewritten safely.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (tone_sb.pending_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Programs a full tone setting; the block must be idle. Optionally fills
	// the unused upper register bits with noise, which the block must ignore.
	task automatic set_tone(input wave_t wave, input logic [31:0] tuning,
			input logic [14:0] gain, input bit noisy);
		logic [31:0] wave_word;
		logic [31:0] gain_word;
		wave_word = noisy ? {$urandom() & 32'hFFFF_FFFC} | 32'(wave) : 32'(wave);
		gain_word = noisy ? {$urandom() & 32'hFFFF_8000} | 32'(gain) : 32'(gain);
		write_reg(CFG_WAVE_SELECT, wave_word);
		write_reg(CFG_PHASE_INCREMENT, tuning);
		write_reg(CFG_AMPLITUDE, gain_word);
		tone_settings++;
	endtask

	// Plays a few ticks; bit i of restarts restarts the phase on tick i.
	task automatic play(input int count, input logic [7:0] restarts);
		for (int i = 0; i < count; i++)
			send_tick(restarts[i]);
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Directed part: about two dozen ticks aimed at the edges of each shape.
	// ------------------------------------------------------------------------
	task automatic run_directed();
		// Straight out of reset every register is zero, so the output is zero.
		play(2, 8'b10);
		// Quarter-turn steps land on zero, peak, zero crossing and trough.
		set_tone(WAVE_SINE, 32'h4000_0000, 15'h7FFF, 1'b0);
		play(5, 8'b00001);
		set_tone(WAVE_SQUARE, 32'h4000_0000, 15'h7FFF, 1'b1);
		play(4, 8'b0001);
		// Triangle at phase zero is the negative peak, at one half the positive.
		set_tone(WAVE_TRIANGLE, 32'h4000_0000, 15'h7FFF, 1'b0);
		play(4, 8'b0001);
		// Largest tuning word walks the phase backwards to the top of the ramp.
		set_tone(WAVE_SAWTOOTH, 32'hFFFF_FFFF, 15'h7FFF, 1'b0);
		play(3, 8'b001);
		// Zero gain silences any shape.
		set_tone(WAVE_SINE, 32'h1234_5678, 15'h0000, 1'b0);
		play(2, 8'b01);
		// Zero tuning word silences even a full-scale tone.
		set_tone(WAVE_TRIANGLE, 32'h0000_0000, 15'h7FFF, 1'b0);
		play(2, 8'b01);
		// The unused register index must leave the setting alone.
		write_reg(2'd3, $urandom());
		set_tone(WAVE_SQUARE, 32'hC000_0000, 15'h0001, 1'b0);
		play(2, 8'b01);
	endtask

	// ------------------------------------------------------------------------
	// Random part: a series of random tone settings, each played for a burst
	// of ticks with occasional phase restarts.
	// ------------------------------------------------------------------------
	function automatic logic [31:0] pick_tuning();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h0000_0001;
			3:       return 32'h1 << $urandom_range(31);
			4, 5:    return 32'($urandom_range(32'h0040_0000, 1));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [14:0] pick_gain();
		case ($urandom_range(9))
			0:       return 15'h0000;
			1, 2:    return 15'h7FFF;
			3:       return 15'h0001;
			default: return 15'($urandom());
		endcase
	endfunction

	task automatic run_random(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			set_tone(wave_t'($urandom_range(3)), pick_tuning(), pick_gain(),
				$urandom_range(3) == 0);
			burst = $urandom_range(8, 60);
			for (int i = 0; i < burst; i++)
				send_tick($urandom_range(99) < 8);
			sent += burst;
			drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Slow sink, mostly busy source.
		send_idle_pct  = 8;
		recv_stall_pct = 54;
		run_directed();
		run_random(625);

		// Sparse source, mostly ready sink.
		send_idle_pct  = 54;
		recv_stall_pct = 8;
		run_random(625);

		// Full rate in both directions.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(625);

		drain();
		$display("Covered %0d tone settings and %0d ticks, %0d of them with a phase restart.",
			tone_settings, tone_sb.checked, tone_sb.restarts);
		$display("Samples per shape: sine %0d, sawtooth %0d, square %0d, triangle %0d.",
			tone_sb.per_wave[0], tone_sb.per_wave[1], tone_sb.per_wave[2],
			tone_sb.per_wave[3]);
		if (tone_sb.mismatches == 0 && tone_sb.pending_samples.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
